/* sv/sal_pkg.sv */
// Package with the shared constants, payload types and control struct of the shifting array list.
package sal_pkg;

    localparam int DEPTH       = 64;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int IDX_FIELD_W = 7;
    localparam int LEN_FIELD_W = 7;
    localparam int LEN_W       = $clog2(DEPTH + 1);
    localparam int CMP_W       = (LEN_W > IDX_FIELD_W) ? LEN_W : IDX_FIELD_W;
    localparam int GROUP_SIZE  = 32;
    localparam int NUM_GROUPS  = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam logic [OP_W-1:0] OP_READ   = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_RESIZE = 3'd4;

    typedef logic [CMP_W-1:0] cmp_t;
    typedef logic [LEN_W-1:0] len_t;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [IDX_FIELD_W-1:0] index_or_length;
        logic signed [DATA_W-1:0] value;
    } sal_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [LEN_FIELD_W-1:0]   list_length;
        logic                     error;
    } sal_rsp_t;

    typedef struct packed {
        logic load_new;
        logic take_lower;
        logic take_upper;
        logic clear;
        logic sel;
    } sal_cell_ctrl_t;

endpackage

/* sv/shifting_array_list_core.sv */
// Top level of the shifting array list: request handling, the chain of cells and the read tree.
// The list lives in a chain of DEPTH cells that all shift in the same cycle, so an insert or a
// remove costs no more than a write. Each transaction is handled on its own: it is taken, then
// executed against the chain in the next cycle, and its response is then held until taken. A
// read also passes through the ST_READ state, as its value passes through a registered OR tree
// over groups of 32 cells. A new transaction is accepted only once the response has been taken.
// Errors leave the list unchanged.
module shifting_array_list_core
    import sal_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  sal_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output sal_rsp_t rsp
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_READ = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t   state_reg;
    state_t   state_next;
    sal_req_t req_reg;
    len_t     len_reg;
    len_t     len_next;
    sal_rsp_t rsp_reg;
    sal_rsp_t rsp_next;

    logic signed [DATA_W-1:0] group_reg  [NUM_GROUPS];
    logic signed [DATA_W-1:0] group_next [NUM_GROUPS];

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic signed [DATA_W-1:0] cell_sel  [DEPTH];
    sal_cell_ctrl_t           cell_ctrl [DEPTH];

    cmp_t idx_ext;
    cmp_t len_ext;
    logic exec;
    logic idx_lt_len;
    logic idx_le_len;
    logic ok_read;
    logic ok_write;
    logic ok_insert;
    logic ok_remove;
    logic ok_resize;
    logic op_ok;
    logic signed [DATA_W-1:0] tree_value;

    assign idx_ext    = cmp_t'(req_reg.index_or_length);
    assign len_ext    = cmp_t'(len_reg);
    assign exec       = (state_reg == ST_EXEC);
    assign idx_lt_len = (idx_ext < len_ext);
    assign idx_le_len = (idx_ext <= len_ext);

    assign ok_read   = (req_reg.op == OP_READ) && idx_lt_len;
    assign ok_write  = (req_reg.op == OP_WRITE) && idx_lt_len;
    assign ok_insert = (req_reg.op == OP_INSERT) && idx_le_len && (len_ext < cmp_t'(DEPTH));
    assign ok_remove = (req_reg.op == OP_REMOVE) && idx_lt_len;
    assign ok_resize = (req_reg.op == OP_RESIZE) && (idx_ext <= cmp_t'(DEPTH));
    assign op_ok     = ok_read || ok_write || ok_insert || ok_remove || ok_resize;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic signed [DATA_W-1:0] lower_data;
            logic signed [DATA_W-1:0] upper_data;

            if (i == 0)
            begin : g_first
                assign lower_data = '0;
            end
            else
            begin : g_mid_lo
                assign lower_data = cell_data[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign upper_data = '0;
            end
            else
            begin : g_mid_hi
                assign upper_data = cell_data[i+1];
            end

            assign cell_ctrl[i].load_new   = exec && (ok_write || ok_insert)
                                             && (idx_ext == cmp_t'(i));
            assign cell_ctrl[i].take_lower = exec && ok_insert && (cmp_t'(i) > idx_ext)
                                             && (cmp_t'(i) <= len_ext);
            assign cell_ctrl[i].take_upper = exec && ok_remove && (cmp_t'(i) >= idx_ext)
                                             && ((cmp_t'(i) + cmp_t'(1)) < len_ext);
            assign cell_ctrl[i].clear      = exec && ok_remove
                                             && ((cmp_t'(i) + cmp_t'(1)) == len_ext);
            assign cell_ctrl[i].sel        = (idx_ext == cmp_t'(i));

            sal_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl[i]),
                .new_value (req_reg.value),
                .lower     (lower_data),
                .upper     (upper_data),
                .data      (cell_data[i]),
                .sel_data  (cell_sel[i])
            );
        end
    endgenerate

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                if (g * GROUP_SIZE + j < DEPTH)
                begin
                    group_next[g] = group_next[g] | cell_sel[g * GROUP_SIZE + j];
                end
            end
        end
    end

    always_comb
    begin
        tree_value = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            tree_value = tree_value | group_reg[g];
        end
    end

    always_comb
    begin
        len_next = len_reg;
        if (ok_insert)
        begin
            len_next = len_reg + len_t'(1);
        end
        else if (ok_remove)
        begin
            len_next = len_reg - len_t'(1);
        end
        else if (ok_resize)
        begin
            len_next = len_t'(req_reg.index_or_length);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rsp_next   = rsp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                rsp_next.read_value  = '0;
                rsp_next.list_length = LEN_FIELD_W'(len_next);
                rsp_next.error       = !op_ok;
                state_next           = ok_read ? ST_READ : ST_DONE;
            end
            ST_READ:
            begin
                rsp_next.read_value = tree_value;
                state_next          = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec)
            begin
                len_reg <= len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (state_reg == ST_IDLE)
        begin
            req_reg <= req;
        end
        if (exec)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_DONE);
    assign rsp       = rsp_reg;

endmodule

/* sv/sal_cell.sv */
// One storage cell of the list chain, which loads, shifts from a neighbour or clears its entry.
module sal_cell
    import sal_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sal_cell_ctrl_t           ctrl,
    input  logic signed [DATA_W-1:0] new_value,
    input  logic signed [DATA_W-1:0] lower,
    input  logic signed [DATA_W-1:0] upper,
    output logic signed [DATA_W-1:0] data,
    output logic signed [DATA_W-1:0] sel_data
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load_new)
        begin
            data_next = new_value;
        end
        else if (ctrl.take_lower)
        begin
            data_next = lower;
        end
        else if (ctrl.take_upper)
        begin
            data_next = upper;
        end
        else if (ctrl.clear)
        begin
            data_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data     = data_reg;
    assign sel_data = ctrl.sel ? data_reg : '0;

endmodule
